>>> src/svsl_pkg.sv
// svsl_pkg: shared widths, register indexes, controller states and handshake structs
// for the vector slew limiter; no dependencies
package svsl_pkg;

    localparam int DATA_W   = 16;   // q4.12 lane value
    localparam int DELTA_W  = 17;   // lane change, signed
    localparam int STEP_W   = 15;   // max_step register
    localparam int PROD_W   = 32;   // magnitude times step
    localparam int QUOT_W   = 15;   // scaled change, never above max_step
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_MODE = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_MUL,
        ST_START,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic load_in;
        logic scan;
        logic decide;
        logic mul;
        logic div_start;
        logic store_lane;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic in_valid;
        logic lane_last;
        logic need_scale;
        logic div_done;
        logic out_free;
    } t_dp_sts;

    function automatic logic [DELTA_W-1:0] mag17(input logic signed [DELTA_W-1:0] v);
        mag17 = v[DELTA_W-1] ? DELTA_W'(-v) : DELTA_W'(v);
    endfunction

endpackage

>>> src/svsl_in_if.sv
// svsl_in_if: input channel carrying the commanded lane values
// depends on svsl_pkg
interface svsl_in_if #(parameter int LANES = 4) ();
    import svsl_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [LANES-1:0][DATA_W-1:0]  cmd_lane;

    modport source (output valid, output cmd_lane, input ready);
    modport sink (input valid, input cmd_lane, output ready);
endinterface

>>> src/svsl_out_if.sv
// svsl_out_if: result channel carrying the limited lane values and the limit flag
// depends on svsl_pkg
interface svsl_out_if #(parameter int LANES = 4) ();
    import svsl_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [LANES-1:0][DATA_W-1:0]  out_lane;
    logic                          was_limited;

    modport source (output valid, output out_lane, output was_limited, input ready);
    modport sink (input valid, input out_lane, input was_limited, output ready);
endinterface

>>> src/svsl_div.sv
// svsl_div: restoring divider, one quotient bit per cycle, quotient known to fit QUOT_W
// depends on svsl_pkg
module svsl_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [svsl_pkg::PROD_W-1:0]   i_dividend,
    input  logic [svsl_pkg::DELTA_W-1:0]  i_divisor,
    output logic                          o_done,
    output logic [svsl_pkg::QUOT_W-1:0]   o_quot
);
    import svsl_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [DELTA_W-1:0] r_rem;
    logic [QUOT_W-1:0]  r_quo;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;

    logic [DELTA_W:0]   n_trial;
    logic               n_ge;
    logic [DELTA_W:0]   n_rem;

    always_comb begin
        n_trial = {r_rem, r_quo[QUOT_W-1]};
        n_ge    = n_trial >= {1'b0, i_divisor};
        n_rem   = n_ge ? (n_trial - {1'b0, i_divisor}) : n_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            // high part is below the divisor since the quotient fits QUOT_W bits
            r_rem  <= i_dividend[PROD_W-1:QUOT_W];
            r_quo  <= i_dividend[QUOT_W-1:0];
            r_cnt  <= '0;
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_rem <= DELTA_W'(n_rem);
            r_quo <= {r_quo[QUOT_W-2:0], n_ge};
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(QUOT_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

>>> src/svsl_dp.sv
// svsl_dp: lane registers, config registers, scan, clamp, scaling and the output register
// depends on svsl_pkg and svsl_div
module svsl_dp #(
    parameter int LANES = 4
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_cfg_we,
    input  logic [svsl_pkg::CFG_IDX_W-1:0]              i_cfg_idx,
    input  logic [svsl_pkg::STEP_W-1:0]                 i_cfg_data,
    input  svsl_pkg::t_dp_cmd                           i_cmd,
    output svsl_pkg::t_dp_sts                           o_sts,
    input  logic                                        i_in_valid,
    input  logic [LANES-1:0][svsl_pkg::DATA_W-1:0]      i_cmd_lane,
    input  logic                                        i_out_ready,
    output logic                                        o_out_valid,
    output logic [LANES-1:0][svsl_pkg::DATA_W-1:0]      o_out_lane,
    output logic                                        o_was_limited
);
    import svsl_pkg::*;

    localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;

    logic [STEP_W-1:0]          r_max_step;
    logic                       r_sync_mode;
    logic signed [DATA_W-1:0]   r_prev [LANES];
    logic signed [DATA_W-1:0]   r_cmd [LANES];
    logic signed [DATA_W-1:0]   r_res [LANES];
    logic signed [DELTA_W-1:0]  r_delta [LANES];
    logic [DATA_W-1:0]          r_out [LANES];
    logic [DELTA_W-1:0]         r_largest;
    logic [IDX_W-1:0]           r_idx;
    logic                       r_limited;
    logic                       r_out_limited;
    logic                       r_out_valid;
    logic [PROD_W-1:0]          r_prod;

    logic [DELTA_W-1:0]         cur_mag;
    logic                       lane_last;
    logic                       need_scale;
    logic signed [DELTA_W-1:0]  step_s;
    logic signed [DELTA_W-1:0]  clamp_d [LANES];
    logic signed [DATA_W-1:0]   clamp_res [LANES];
    logic [LANES-1:0]           clamp_hit;
    logic                       div_done;
    logic [QUOT_W-1:0]          quot;
    logic signed [DELTA_W-1:0]  scaled_d;
    logic signed [DELTA_W-1:0]  scaled_sum;

    svsl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_largest),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    always_comb begin
        cur_mag    = mag17(r_delta[r_idx]);
        lane_last  = (r_idx == IDX_W'(LANES - 1));
        step_s     = $signed({2'b00, r_max_step});
        need_scale = r_sync_mode && (r_max_step != '0)
                     && (r_largest > {2'b00, r_max_step});
        for (int i = 0; i < LANES; i++) begin
            if (r_delta[i] > step_s) begin
                clamp_d[i]   = step_s;
                clamp_hit[i] = 1'b1;
            end else if (r_delta[i] < -step_s) begin
                clamp_d[i]   = -step_s;
                clamp_hit[i] = 1'b1;
            end else begin
                clamp_d[i]   = r_delta[i];
                clamp_hit[i] = 1'b0;
            end
            clamp_res[i] = DATA_W'(DELTA_W'(r_prev[i]) + clamp_d[i]);
        end
        // apply the sign of the lane change to the truncated quotient
        scaled_d   = r_delta[r_idx][DELTA_W-1] ? -$signed({2'b00, quot})
                                               : $signed({2'b00, quot});
        scaled_sum = DELTA_W'(r_prev[r_idx]) + scaled_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_step  <= '0;
            r_sync_mode <= 1'b1;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < LANES; i++) begin
                r_prev[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_MAX_STEP:  r_max_step  <= i_cfg_data;
                    REG_SYNC_MODE: r_sync_mode <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (i_cmd.load_in) begin
                for (int i = 0; i < LANES; i++) begin
                    r_cmd[i]   <= $signed(i_cmd_lane[i]);
                    r_delta[i] <= DELTA_W'($signed(i_cmd_lane[i])) - DELTA_W'(r_prev[i]);
                end
                r_idx     <= '0;
                r_largest <= '0;
                r_limited <= 1'b0;
            end

            if (i_cmd.scan) begin
                if (cur_mag > r_largest) begin
                    r_largest <= cur_mag;
                end
                r_idx <= lane_last ? '0 : r_idx + 1'b1;
            end

            if (i_cmd.decide) begin
                if (need_scale) begin
                    r_limited <= 1'b1;
                end else if (r_sync_mode) begin
                    for (int i = 0; i < LANES; i++) begin
                        r_res[i] <= r_cmd[i];
                    end
                end else begin
                    for (int i = 0; i < LANES; i++) begin
                        r_res[i] <= clamp_res[i];
                    end
                    r_limited <= |clamp_hit;
                end
            end

            if (i_cmd.mul) begin
                r_prod <= PROD_W'(cur_mag) * PROD_W'(r_max_step);
            end

            if (i_cmd.store_lane) begin
                r_res[r_idx] <= DATA_W'(scaled_sum);
                r_idx        <= lane_last ? '0 : r_idx + 1'b1;
            end

            if (i_cmd.commit) begin
                for (int i = 0; i < LANES; i++) begin
                    r_out[i]  <= r_res[i];
                    r_prev[i] <= r_res[i];
                end
                r_out_limited <= r_limited;
                r_out_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            o_out_lane[i] = r_out[i];
        end
        o_sts.in_valid   = i_in_valid;
        o_sts.lane_last  = lane_last;
        o_sts.need_scale = need_scale;
        o_sts.div_done   = div_done;
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_was_limited = r_out_limited;

endmodule

>>> src/svsl_ctrl.sv
// svsl_ctrl: sequencer for scan, decide, per-lane multiply and divide, and result commit
// depends on svsl_pkg
module svsl_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  svsl_pkg::t_dp_sts  i_sts,
    output svsl_pkg::t_dp_cmd  o_cmd
);
    import svsl_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.lane_last) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = i_sts.need_scale ? ST_MUL : ST_DONE;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_START;
            end
            ST_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV;
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.store_lane = 1'b1;
                    n_state          = i_sts.lane_last ? ST_DONE : ST_MUL;
                end
            end
            ST_DONE: begin
                // wait for room in the output register
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

>>> src/sync_vector_slew_limiter.sv
// sync_vector_slew_limiter: top level joining controller, datapath and channel interfaces
// depends on svsl_pkg, svsl_in_if, svsl_out_if, svsl_ctrl, svsl_dp
//
// usage
//   i_in carries one beat of LANES commanded values (signed q4.12); o_out returns one
//   beat per input with the rate-limited values and a flag set when any lane was cut.
//   the config port writes max_step (index 0) and sync_mode (index 1) on any cycle
//   with i_cfg_we high; write only while no beat is in flight.
//   flow: when no scaling is needed, the block scans each lane, decides and commits the
//   result into the output register. when sync scaling applies, each lane adds a multiply,
//   a divider start and the divider steps up to its done flag. one beat is in work at a
//   time and the next input beat is taken the cycle after the commit.
//   reset clears the previous outputs to zero, max_step to zero, sync_mode to one and
//   empties the output register.
//   a stalled receiver holds the result in the output register; the block still takes
//   the next input beat and works it up to the commit, where it waits for the slot.
module sync_vector_slew_limiter #(
    parameter int LANES = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [svsl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [svsl_pkg::STEP_W-1:0]       i_cfg_data,
    svsl_in_if.sink                           i_in,
    svsl_out_if.source                        o_out
);
    import svsl_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    svsl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    svsl_dp #(
        .LANES (LANES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_in_valid    (i_in.valid),
        .i_cmd_lane    (i_in.cmd_lane),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_out_lane    (o_out.out_lane),
        .o_was_limited (o_out.was_limited)
    );

    assign i_in.ready = cmd.in_ready;

endmodule
